// ===== hw/rtl/bq_pkg.sv =====
// Shared widths, register indexes and structure types for the biquad filter.
`timescale 1ns / 1ps

package bq_pkg;

  // Sample and coefficient formats: Q16.16 samples, Q3.28 coefficients.
  localparam int SAMPLE_W   = 32;
  localparam int COEF_W     = 32;
  localparam int FRAC_SHIFT = 28;

  // One full product and the exact sum of five products with rounding headroom.
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam int YFULL_W = ACC_W - FRAC_SHIFT;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  // Count of history samples in the current series; it stops at two.
  localparam int SEEN_W = 2;
  localparam logic [SEEN_W-1:0] SEEN_NONE = 2'd0;
  localparam logic [SEEN_W-1:0] SEEN_ONE  = 2'd1;
  localparam logic [SEEN_W-1:0] SEEN_FULL = 2'd2;

  // Output clamp limits.
  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic signed [SAMPLE_W-1:0] y1;
    logic signed [SAMPLE_W-1:0] y2;
    logic [SEEN_W-1:0]          seen;
  } hist_t;

endpackage

// ===== hw/rtl/bq_ifs.sv =====
// Valid/ready stream interfaces for the filter's sample and result channels.
`timescale 1ns / 1ps

interface bq_in_if;
  import bq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       start_of_series;

  modport source (output valid, output sample, output start_of_series, input ready);
  modport sink (input valid, input sample, input start_of_series, output ready);
endinterface

interface bq_out_if;
  import bq_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] filtered;
  logic                       saturated;

  modport source (output valid, output filtered, output saturated, input ready);
  modport sink (input valid, input filtered, input saturated, output ready);
endinterface

// ===== hw/rtl/second_order_iir_filter.sv =====
// Top level of the second-order direct-form-1 IIR filter.
// The filter takes one Q16.16 sample word per clock and gives one rounded,
// saturated Q16.16 result word per clock while the output is not stalled,
// with a flag when the result was clipped. A word is captured in an input
// register at its handshake, and its result is loaded into the output
// register once that register is free or emptying. The rate of one word per
// cycle is set by the feedback path: the previous result is registered in the
// history and enters the next word's multiply, so the five
// 32x32 products, their exact sum, rounding and clamp sit in one
// register-to-register path. The output register parts the two channels, so a
// new word is taken while a finished result still waits. Coefficients are
// Q3.28, written at indexes 0 to 4 (b0, b1, b2, a1, a2) while the filter is
// idle; a word with start_of_series high, or the first word after reset,
// begins a series with zero history.
`timescale 1ns / 1ps

module second_order_iir_filter
  import bq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bq_in_if.sink                 in_ch,
  bq_out_if.source              out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  coef_t                      coef;
  hist_t                      hist;
  logic                       advance;
  logic                       in_valid_r;
  logic                       in_valid_nxt;
  logic signed [SAMPLE_W-1:0] in_x_r;
  logic                       in_start_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_y_r;
  logic                       out_sat_r;
  logic signed [SAMPLE_W-1:0] y_nxt;
  logic                       sat_nxt;

  bq_coef_regs u_coef_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  bq_history u_history (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .start   (in_start_r),
    .x       (in_x_r),
    .y       (y_nxt),
    .hist    (hist)
  );

  bq_datapath u_datapath (
    .coef  (coef),
    .hist  (hist),
    .x     (in_x_r),
    .start (in_start_r),
    .y     (y_nxt),
    .sat   (sat_nxt)
  );

  // The held word moves on whenever the output register is free or emptying.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Handshake state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input and output word registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_x_r     <= in_ch.sample;
      in_start_r <= in_ch.start_of_series;
    end
    if (advance) begin
      out_y_r   <= y_nxt;
      out_sat_r <= sat_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.filtered  = out_y_r;
  assign out_ch.saturated = out_sat_r;

  // The history count never passes two.
  assert property (@(posedge clk) disable iff (!rst_n)
    hist.seen <= SEEN_FULL)
    else $error("history count out of range");

  // A word that starts a series leaves exactly one word of history behind.
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_start_r |=> hist.seen == SEEN_ONE)
    else $error("series start did not restart the history");

  // A clipped result sits at one of the two range limits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> (out_y_r == OUT_MAX) || (out_y_r == OUT_MIN))
    else $error("saturation flag without a clamped value");

  // A result still waiting is never overwritten by the next word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_y_r) && out_valid_r)
    else $error("pending result overwritten");

endmodule

// ===== hw/rtl/bq_coef_regs.sv =====
// Coefficient register file written through the configuration port.
`timescale 1ns / 1ps

module bq_coef_regs
  import bq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output coef_t                 coef
);

  coef_t coef_r;
  coef_t coef_nxt;

  // Decode the register index; indexes past the last register are dropped.
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_B0:  coef_nxt.b0 = $signed(cfg_wdata);
        REG_B1:  coef_nxt.b1 = $signed(cfg_wdata);
        REG_B2:  coef_nxt.b2 = $signed(cfg_wdata);
        REG_A1:  coef_nxt.a1 = $signed(cfg_wdata);
        REG_A2:  coef_nxt.a2 = $signed(cfg_wdata);
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ===== hw/rtl/bq_history.sv =====
// Two-deep sample and result history with the per-series fill count.
`timescale 1ns / 1ps

module bq_history
  import bq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic signed [SAMPLE_W-1:0] y,
  output hist_t                      hist
);

  hist_t             hist_r;
  hist_t             hist_nxt;
  logic [SEEN_W-1:0] seen_eff;

  // A new series forgets the older history before this word is counted.
  always_comb begin
    seen_eff = start ? SEEN_NONE : hist_r.seen;
    hist_nxt = hist_r;
    if (advance) begin
      hist_nxt.x2 = hist_r.x1;
      hist_nxt.x1 = x;
      hist_nxt.y2 = hist_r.y1;
      hist_nxt.y1 = y;
      hist_nxt.seen = (seen_eff == SEEN_FULL) ? SEEN_FULL : seen_eff + SEEN_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  assign hist = hist_r;

endmodule

// ===== hw/rtl/bq_datapath.sv =====
// Five-term multiply-accumulate with rounding and saturation for one sample.
`timescale 1ns / 1ps

module bq_datapath
  import bq_pkg::*;
(
  input  coef_t                      coef,
  input  hist_t                      hist,
  input  logic signed [SAMPLE_W-1:0] x,
  input  logic                       start,
  output logic signed [SAMPLE_W-1:0] y,
  output logic                       sat
);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_SHIFT - 1);

  logic                       use1;
  logic                       use2;
  logic signed [SAMPLE_W-1:0] x1_op;
  logic signed [SAMPLE_W-1:0] x2_op;
  logic signed [SAMPLE_W-1:0] y1_op;
  logic signed [SAMPLE_W-1:0] y2_op;
  logic signed [PROD_W-1:0]   p_b0;
  logic signed [PROD_W-1:0]   p_b1;
  logic signed [PROD_W-1:0]   p_b2;
  logic signed [PROD_W-1:0]   p_a1;
  logic signed [PROD_W-1:0]   p_a2;
  logic signed [ACC_W-1:0]    acc;
  logic signed [YFULL_W-1:0]  y_full;
  logic                       in_range;

  // History before the start of a series counts as zero.
  always_comb begin
    use1  = !start && (hist.seen != SEEN_NONE);
    use2  = !start && (hist.seen == SEEN_FULL);
    x1_op = use1 ? hist.x1 : '0;
    y1_op = use1 ? hist.y1 : '0;
    x2_op = use2 ? hist.x2 : '0;
    y2_op = use2 ? hist.y2 : '0;
  end

  // Five independent full-precision products.
  always_comb begin
    p_b0 = PROD_W'(coef.b0) * PROD_W'(x);
    p_b1 = PROD_W'(coef.b1) * PROD_W'(x1_op);
    p_b2 = PROD_W'(coef.b2) * PROD_W'(x2_op);
    p_a1 = PROD_W'(coef.a1) * PROD_W'(y1_op);
    p_a2 = PROD_W'(coef.a2) * PROD_W'(y2_op);
  end

  // Exact sum, round half up, then drop the coefficient fraction bits.
  always_comb begin
    acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
        - ACC_W'(p_a1) - ACC_W'(p_a2) + ROUND_HALF;
    y_full = $signed(acc[ACC_W-1:FRAC_SHIFT]);
  end

  // Clamp to the 32-bit sample range and flag the clip.
  always_comb begin
    in_range = (&y_full[YFULL_W-1:SAMPLE_W-1]) || !(|y_full[YFULL_W-1:SAMPLE_W-1]);
    sat      = !in_range;
    if (in_range) begin
      y = $signed(y_full[SAMPLE_W-1:0]);
    end else if (y_full[YFULL_W-1]) begin
      y = OUT_MIN;
    end else begin
      y = OUT_MAX;
    end
  end

endmodule

// ===== tb/second_order_iir_filter_tb.sv =====
// Self-checking testbench for the biquad filter: bit-exact prediction and randomized traffic.
`timescale 1ns / 1ps

module second_order_iir_filter_tb;
  import bq_pkg::*;

  // Exact accumulator wide enough for five full products plus rounding.
  typedef logic signed [71:0] wide_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       first;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       saturated;
  } result_t;

  localparam logic signed [COEF_W-1:0] GAIN_ONE  = 32'sh1000_0000;
  localparam logic signed [COEF_W-1:0] GAIN_HALF = 32'sh0800_0000;
  localparam logic signed [COEF_W-1:0] GAIN_MAX  = 32'sh7fff_ffff;
  localparam logic signed [COEF_W-1:0] GAIN_MIN  = 32'sh8000_0000;
  localparam int RAND_PHASES   = 5;
  localparam int WORDS_PER_SET = 125;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_AT       = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_SHOWN     = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bq_in_if  in_ch ();
  bq_out_if out_ch ();

  second_order_iir_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: coefficients and the history of the current series.
  logic signed [COEF_W-1:0]   gain [0:4];
  logic signed [SAMPLE_W-1:0] x_hist [0:1];
  logic signed [SAMPLE_W-1:0] y_hist [0:1];
  logic [SEEN_W-1:0]          series_len;

  in_word_t pending_q [$];
  result_t  expected_q [$];
  in_word_t next_word;
  result_t  want;

  int  queued_words   = 0;
  int  accepted_words = 0;
  int  errors         = 0;
  logic in_fire       = 1'b0;
  logic quiet_tail    = 1'b0;
  int  tx_gap = 0, tx_calm = 0;
  int  rx_gap = 0, rx_calm = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Filter one word the way the hardware should, and advance the history.
  function automatic result_t filter_word(input logic signed [SAMPLE_W-1:0] x,
                                          input logic first);
    wide_t   acc;
    wide_t   yw;
    result_t r;
    if (first) series_len = SEEN_NONE;
    acc = wide_t'(gain[REG_B0]) * wide_t'(x);
    if (series_len >= SEEN_ONE) begin
      acc = acc + wide_t'(gain[REG_B1]) * wide_t'(x_hist[0])
                - wide_t'(gain[REG_A1]) * wide_t'(y_hist[0]);
    end
    if (series_len >= SEEN_FULL) begin
      acc = acc + wide_t'(gain[REG_B2]) * wide_t'(x_hist[1])
                - wide_t'(gain[REG_A2]) * wide_t'(y_hist[1]);
    end
    // Round half toward plus infinity, then clamp to 32 bits.
    yw = (acc + (wide_t'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
    r.saturated = 1'b0;
    if (yw > wide_t'(OUT_MAX)) begin
      r.filtered  = OUT_MAX;
      r.saturated = 1'b1;
    end else if (yw < wide_t'(OUT_MIN)) begin
      r.filtered  = OUT_MIN;
      r.saturated = 1'b1;
    end else begin
      r.filtered = yw[SAMPLE_W-1:0];
    end
    x_hist[1] = x_hist[0];
    x_hist[0] = x;
    y_hist[1] = y_hist[0];
    y_hist[0] = r.filtered;
    if (series_len < SEEN_FULL) series_len = series_len + 1'b1;
    return r;
  endfunction

  // One register write; the block is idle whenever this runs.
  task automatic write_gain(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx <= REG_A2) gain[idx] = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_gains(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
    write_gain(REG_B0, b0);
    write_gain(REG_B1, b1);
    write_gain(REG_B2, b2);
    write_gain(REG_A1, a1);
    write_gain(REG_A2, a2);
  endtask

  task automatic queue_word(input logic signed [SAMPLE_W-1:0] x, input logic first);
    pending_q.push_back('{sample: x, first: first});
    queued_words++;
  endtask

  // Wait until every queued word has its result back, then let the pipe settle.
  task automatic drain();
    while (accepted_words != queued_words || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: offers queued words with random idle bursts and calm stretches.
  always @(negedge clk) begin
    if (tx_calm != 0) tx_calm <= tx_calm - 1;
    else if ($urandom_range(0, 199) == 0) tx_calm <= $urandom_range(30, 120);
    if (!in_ch.valid || in_fire) begin
      if (tx_gap != 0) begin
        in_ch.valid <= 1'b0;
        tx_gap      <= tx_gap - 1;
      end else if (!quiet_tail && tx_calm == 0 && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        tx_gap      <= $urandom_range(0, 15);
      end else if (pending_q.size() != 0) begin
        next_word             = pending_q.pop_front();
        in_ch.valid           <= 1'b1;
        in_ch.sample          <= next_word.sample;
        in_ch.start_of_series <= next_word.first;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once traffic is flowing.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_words >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Receiver: random stall bursts on top of the long hold-off.
  always @(negedge clk) begin
    if (rx_calm != 0) rx_calm <= rx_calm - 1;
    else if ($urandom_range(0, 199) == 0) rx_calm <= $urandom_range(30, 120);
    if (rx_gap != 0) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= rx_gap - 1;
    end else if (!quiet_tail && rx_calm == 0 && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      rx_gap       <= $urandom_range(0, 15);
    end else begin
      out_ch.ready <= (hold_left == 0);
    end
  end

  // Monitor: check each result word, and predict each accepted input word.
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("unexpected result word: filtered %0d saturated %0b",
                     out_ch.filtered, out_ch.saturated);
        end else begin
          want = expected_q.pop_front();
          if (want.filtered !== out_ch.filtered || want.saturated !== out_ch.saturated) begin
            errors++;
            if (errors <= MAX_SHOWN)
              $display("mismatch: filtered exp %0d got %0d, saturated exp %0b got %0b",
                       want.filtered, out_ch.filtered, want.saturated, out_ch.saturated);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(filter_word(in_ch.sample, in_ch.start_of_series));
        accepted_words++;
      end
    end
  end

  // Stimulus sequence: directed phases, then randomized coefficient sets.
  initial begin : stimulus
    logic signed [COEF_W-1:0]   g [0:4];
    logic signed [SAMPLE_W-1:0] x;
    int mode;
    in_ch.valid           = 1'b0;
    in_ch.sample          = '0;
    in_ch.start_of_series = 1'b0;
    out_ch.ready          = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_wdata             = '0;
    rst_n                 = 1'b0;
    for (int k = 0; k <= 4; k++) gain[k] = '0;
    x_hist[0] = '0;
    x_hist[1] = '0;
    y_hist[0] = '0;
    y_hist[1] = '0;
    series_len = SEEN_NONE;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Only b0 and b1 written; the rest keep their reset value. Writes past
    // the last register must be ignored. First word after reset has no start flag.
    write_gain(REG_B0, GAIN_ONE);
    write_gain(REG_B1, GAIN_HALF);
    for (int k = int'(REG_A2) + 1; k < (1 << CFG_IDX_W); k++)
      write_gain(CFG_IDX_W'(k), $urandom());
    queue_word(32'sh0001_0000, 1'b0);
    queue_word(32'sh0002_0000, 1'b0);
    queue_word(-32'sh0001_0000, 1'b0);
    drain();

    // Ordinary filter with series restarts, back to back as well.
    load_gains(32'sh0400_0000, 32'sh0800_0000, 32'sh0400_0000, 32'shf800_0000,
               32'sh0200_0000);
    queue_word(32'sh0004_0000, 1'b1);
    queue_word(32'sh0001_8000, 1'b0);
    queue_word(-32'sh0003_0000, 1'b0);
    queue_word(32'sh0000_4000, 1'b0);
    queue_word(32'sh0002_0000, 1'b1);
    queue_word(-32'sh0001_0000, 1'b1);
    queue_word(32'sh0005_0000, 1'b0);
    queue_word(32'sh0000_0001, 1'b0);
    drain();

    // Most negative gains with extreme samples: saturation both ways.
    load_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
    queue_word(OUT_MAX, 1'b1);
    queue_word(OUT_MIN, 1'b0);
    queue_word(OUT_MAX, 1'b0);
    queue_word(OUT_MIN, 1'b0);
    drain();

    load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
    queue_word(OUT_MAX, 1'b1);
    queue_word(OUT_MAX, 1'b0);
    queue_word(OUT_MIN, 1'b0);
    queue_word('0, 1'b0);
    drain();

    // Exact halves round toward plus infinity.
    load_gains(GAIN_HALF, '0, '0, '0, '0);
    queue_word(32'sh0000_0001, 1'b1);
    queue_word(-32'sh0000_0001, 1'b0);
    queue_word(32'sh0000_0003, 1'b0);
    queue_word(-32'sh0000_0003, 1'b0);
    drain();

    // Random coefficient sets, each followed by a stream of series.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == RAND_PHASES - 1) quiet_tail <= 1'b1;
      mode = $urandom_range(0, 3);
      for (int k = 0; k <= 4; k++) begin
        case (mode)
          0, 1: g[k] = $urandom_range(0, 2 * GAIN_ONE) - GAIN_ONE;
          2:    g[k] = $urandom();
          default: begin
            case ($urandom_range(0, 3))
              0:       g[k] = GAIN_MIN;
              1:       g[k] = GAIN_MAX;
              2:       g[k] = '0;
              default: g[k] = GAIN_ONE;
            endcase
          end
        endcase
      end
      load_gains(g[0], g[1], g[2], g[3], g[4]);
      write_gain(CFG_IDX_W'($urandom_range(int'(REG_A2) + 1, (1 << CFG_IDX_W) - 1)),
                 $urandom());
      for (int n = 0; n < WORDS_PER_SET; n++) begin
        case ($urandom_range(0, 9))
          0, 1: x = $urandom();
          2: begin
            case ($urandom_range(0, 4))
              0:       x = OUT_MAX;
              1:       x = OUT_MIN;
              2:       x = '0;
              3:       x = 32'sh0000_0001;
              default: x = -32'sh0000_0001;
            endcase
          end
          default: x = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        endcase
        queue_word(x, (n == 0) || ($urandom_range(0, 11) == 0));
      end
      drain();
    end

    if (expected_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
